[design/temporal_shortest_path_engine_core_assert.svh]
// assertion macros shared by the engine rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef TEMPORAL_SHORTEST_PATH_ENGINE_CORE_ASSERT_SVH
`define TEMPORAL_SHORTEST_PATH_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TSPE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("tspe check failed");
`define TSPE_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("tspe check failed");
`else
`define TSPE_ASSERT(lbl, clk, rst, prop)
`define TSPE_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[design/tspe_pkg.sv]
// types and constants for the temporal shortest path engine
// no dependencies
package tspe_pkg;

  localparam int TW = 24;
  localparam logic [TW-1:0] DIST_MAX = 24'hFFFFFF;

  localparam logic [1:0] MODE_EDGE  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_NOP   = 2'd3;

  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_WSTART = 2'd1;
  localparam logic [1:0] REG_WEND   = 2'd2;

  typedef struct packed {
    logic [TW-1:0] cost;
    logic [TW-1:0] tm;
  } pair_t;

  typedef struct packed {
    logic old_dom;  // stored pair dominates candidate
    logic new_dom;  // candidate dominates stored pair
    logic later;    // stored arrival after candidate arrival
  } dom_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DEC, ST_LEN, ST_LEN2, ST_SC_RD, ST_SC_CHK, ST_INS,
    ST_SH_RD, ST_SH_CHK, ST_PUT, ST_LP_LEN, ST_LP_LEN2, ST_LP_RD, ST_LP_CHK,
    ST_LP_END, ST_BEST, ST_BEST2, ST_FIN, ST_OUT
  } state_t;

endpackage

[design/tspe_ram.sv]
// single write port, single registered read port memory
// no dependencies
module tspe_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/tspe_dom.sv]
// shared pareto compare unit: dominance both ways and arrival order
// depends on tspe_pkg
module tspe_dom (
  input  tspe_pkg::pair_t entry,
  input  tspe_pkg::pair_t cand,
  output tspe_pkg::dom_t  res
);
  import tspe_pkg::*;

  always_comb begin
    res.old_dom = (entry.cost <= cand.cost) && (entry.tm <= cand.tm);
    res.new_dom = (cand.cost <= entry.cost) && (cand.tm <= entry.tm);
    res.later   = entry.tm > cand.tm;
  end

endmodule

[design/temporal_shortest_path_engine_core.sv]
// one request at a time; in_ready returns with out_valid
// each list entry takes a read state and a check state on the pareto memory read port
// (scan for the latest pair, dominance scan with compaction, shift for insertion)
// reset runs a clearing pass over the vertex table, in_ready low
// a finished result waits in the output register while the next request is taken
`include "temporal_shortest_path_engine_core_assert.svh"
module temporal_shortest_path_engine_core #(
  parameter int NUM_VERTICES = 256,
  parameter int LIST_DEPTH   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  from_vertex,
  input  logic [7:0]  to_vertex,
  input  logic [23:0] start_time,
  input  logic [15:0] duration,
  input  logic [7:0]  query_vertex,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  vertex,
  output logic        reached,
  output logic [23:0] best_distance,
  output logic        improved,
  output logic        edge_used,
  output logic        overflow
);
  import tspe_pkg::*;

  localparam int VW  = $clog2(NUM_VERTICES);
  localparam int VXW = (VW > 8) ? VW : 8;
  localparam int LW  = $clog2(LIST_DEPTH + 1);
  localparam int VIW = LW + 25;
  localparam int PD  = NUM_VERTICES * LIST_DEPTH;
  localparam int PW  = $clog2(PD);

  state_t state, state_next;

  logic [7:0]  source_r;
  logic [23:0] win_start, win_end;

  logic [1:0]  mode_r;
  logic [7:0]  from_r, to_r, q_r;
  logic [23:0] st_r;
  logic [15:0] dur_r;

  pair_t          cur;
  logic [VW-1:0]  cur_v;
  logic           which_to;
  logic [LW-1:0]  n, m, k;
  logic           found;
  logic [23:0]    fd;
  logic [VIW-1:0] vword;
  logic [VW-1:0]  clr_idx;
  logic           clr_reply;
  logic           stopped, ovf;
  logic           improved_r, used_r;

  logic           vi_we;
  logic [VW-1:0]  vi_waddr, vi_raddr;
  logic [VIW-1:0] vi_wdata, vi_rdata;
  logic           pa_we;
  logic [LW-1:0]  pa_k, pa_rk;
  logic [VW-1:0]  pa_rv;
  pair_t          pa_wdata, pa_rdata;
  logic [PW-1:0]  pa_waddr, pa_raddr;
  dom_t           dom;

  logic [24:0]    arr, nd_sum;
  logic [23:0]    nd;
  logic [VXW-1:0] from_ext, to_ext, q_ext;
  logic [VW-1:0]  from_idx, to_idx, q_idx, vtx_idx;
  logic           from_ok, to_ok, vtx_ok, in_win;
  logic           clr_last, vi_better;
  state_t         offer_end;

  assign arr      = {1'b0, st_r} + {9'd0, dur_r};
  assign nd_sum   = {1'b0, fd} + {9'd0, dur_r};
  assign nd       = nd_sum[24] ? DIST_MAX : nd_sum[23:0];
  assign from_ext = VXW'(from_r);
  assign to_ext   = VXW'(to_r);
  assign q_ext    = VXW'(q_r);
  assign from_ok  = from_ext < NUM_VERTICES;
  assign to_ok    = to_ext < NUM_VERTICES;
  assign from_idx = from_ext[VW-1:0];
  assign to_idx   = to_ext[VW-1:0];
  assign q_idx    = q_ext[VW-1:0];
  assign vtx_idx  = (mode_r == MODE_EDGE) ? to_idx : q_idx;
  assign vtx_ok   = (mode_r == MODE_EDGE) ? to_ok : (q_ext < NUM_VERTICES);
  assign in_win   = (st_r >= win_start) && (arr <= {1'b0, win_end});
  assign clr_last = clr_idx == VW'(NUM_VERTICES - 1);
  assign offer_end = which_to ? ST_BEST : ST_LP_LEN;
  assign vi_better = !vi_rdata[24] || (cur.cost < vi_rdata[23:0]);
  assign in_ready = state == ST_IDLE;

  assign pa_waddr = PW'(cur_v) * PW'(LIST_DEPTH) + PW'(pa_k);
  assign pa_raddr = PW'(pa_rv) * PW'(LIST_DEPTH) + PW'(pa_rk);

  tspe_ram #(.WIDTH(VIW), .DEPTH(NUM_VERTICES)) u_vinfo (
    .clk(clk), .we(vi_we), .waddr(vi_waddr), .wdata(vi_wdata),
    .raddr(vi_raddr), .rdata(vi_rdata)
  );

  tspe_ram #(.WIDTH(48), .DEPTH(PD)) u_pareto (
    .clk(clk), .we(pa_we), .waddr(pa_waddr), .wdata(pa_wdata),
    .raddr(pa_raddr), .rdata(pa_rdata)
  );

  tspe_dom u_dom (.entry(pa_rdata), .cand(cur), .res(dom));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLR:     if (clr_last) state_next = clr_reply ? ST_OUT : ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_EDGE:  state_next = ST_DEC;
            MODE_READ:  state_next = ST_FIN;
            MODE_CLEAR: state_next = ST_CLR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_DEC: begin
        if (!stopped && in_win && from_ok && to_ok)
          state_next = (from_r == source_r) ? ST_LEN : ST_LP_LEN;
        else
          state_next = ST_FIN;
      end
      ST_LEN:     state_next = ST_LEN2;
      ST_LEN2:    state_next = (vi_rdata[VIW-1:25] == '0) ? ST_INS : ST_SC_RD;
      ST_SC_RD:   state_next = ST_SC_CHK;
      ST_SC_CHK: begin
        if (dom.old_dom) state_next = offer_end;
        else if (k + LW'(1) == n) state_next = ST_INS;
        else state_next = ST_SC_RD;
      end
      ST_INS: begin
        if (m >= LIST_DEPTH) state_next = offer_end;
        else if (m == '0) state_next = ST_PUT;
        else state_next = ST_SH_RD;
      end
      ST_SH_RD:   state_next = ST_SH_CHK;
      ST_SH_CHK: begin
        if (dom.later) state_next = (k == LW'(1)) ? ST_PUT : ST_SH_RD;
        else state_next = ST_PUT;
      end
      ST_PUT:     state_next = offer_end;
      ST_LP_LEN:  state_next = ST_LP_LEN2;
      ST_LP_LEN2: state_next = (vi_rdata[VIW-1:25] == '0) ? ST_FIN : ST_LP_RD;
      ST_LP_RD:   state_next = ST_LP_CHK;
      ST_LP_CHK:  state_next = (k + LW'(1) == n) ? ST_LP_END : ST_LP_RD;
      ST_LP_END:  state_next = found ? ST_LEN : ST_FIN;
      ST_BEST:    state_next = ST_BEST2;
      ST_BEST2:   state_next = ST_FIN;
      ST_FIN:     state_next = ST_OUT;
      ST_OUT:     if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    vi_we    = 1'b0;
    vi_waddr = cur_v;
    vi_wdata = vword;
    pa_we    = 1'b0;
    pa_k     = k;
    pa_wdata = pa_rdata;
    pa_rk    = k;
    pa_rv    = cur_v;
    case (state)
      ST_LP_LEN, ST_LP_LEN2, ST_LP_RD, ST_LP_CHK: vi_raddr = from_idx;
      ST_BEST, ST_BEST2: vi_raddr = to_idx;
      ST_FIN, ST_OUT:    vi_raddr = vtx_idx;
      default:           vi_raddr = cur_v;
    endcase
    case (state)
      ST_CLR: begin
        vi_we    = 1'b1;
        vi_waddr = clr_idx;
        vi_wdata = {LW'(0), VXW'(clr_idx) == VXW'(source_r), 24'd0};
      end
      ST_SC_CHK: begin
        // keep entries the candidate does not dominate, packed down
        if (!dom.old_dom && !dom.new_dom) begin
          pa_we = 1'b1;
          pa_k  = m;
        end
      end
      ST_INS: begin
        if (m >= LIST_DEPTH) begin
          vi_we    = 1'b1;
          vi_wdata = {m, vword[24:0]};
        end
      end
      ST_SH_RD: pa_rk = k - LW'(1);
      ST_SH_CHK: pa_we = dom.later;
      ST_PUT: begin
        pa_we    = 1'b1;
        pa_wdata = cur;
        vi_we    = 1'b1;
        vi_wdata = {m + LW'(1), vword[24:0]};
      end
      ST_LP_RD: pa_rv = from_idx;
      ST_BEST2: begin
        if (vi_better) begin
          vi_we    = 1'b1;
          vi_waddr = to_idx;
          vi_wdata = {vi_rdata[VIW-1:25], 1'b1, cur.cost};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLR;
      clr_idx    <= '0;
      clr_reply  <= 1'b0;
      stopped    <= 1'b0;
      ovf        <= 1'b0;
      out_valid  <= 1'b0;
      source_r   <= 8'd0;
      win_start  <= 24'd0;
      win_end    <= 24'hFFFFFF;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        case (cfg_index)
          REG_SOURCE: source_r  <= cfg_data[7:0];
          REG_WSTART: win_start <= cfg_data;
          REG_WEND:   win_end   <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      case (state)
        ST_CLR: clr_idx <= clr_last ? '0 : clr_idx + VW'(1);
        ST_IDLE: begin
          if (in_valid) begin
            mode_r     <= mode;
            from_r     <= from_vertex;
            to_r       <= to_vertex;
            st_r       <= start_time;
            dur_r      <= duration;
            q_r        <= query_vertex;
            improved_r <= 1'b0;
            used_r     <= 1'b0;
            if (mode == MODE_CLEAR) begin
              clr_idx   <= '0;
              clr_reply <= 1'b1;
              stopped   <= 1'b0;
              ovf       <= 1'b0;
            end
          end
        end
        ST_DEC: begin
          cur.cost <= 24'd0;
          cur.tm   <= st_r;
          cur_v    <= from_idx;
          which_to <= 1'b0;
          if (!stopped && !in_win && st_r >= win_end) stopped <= 1'b1;
        end
        ST_LEN2: begin
          n     <= vi_rdata[VIW-1:25];
          vword <= vi_rdata;
          k     <= '0;
          m     <= '0;
        end
        ST_SC_CHK: begin
          if (!dom.old_dom && !dom.new_dom) m <= m + LW'(1);
          k <= k + LW'(1);
        end
        ST_INS: begin
          if (m >= LIST_DEPTH) ovf <= 1'b1;
          k <= m;
        end
        ST_SH_CHK: if (dom.later) k <= k - LW'(1);
        ST_LP_LEN2: begin
          n     <= vi_rdata[VIW-1:25];
          k     <= '0;
          found <= 1'b0;
        end
        ST_LP_CHK: begin
          // candidate time holds the edge start here
          if (!dom.later) begin
            found <= 1'b1;
            fd    <= pa_rdata.cost;
          end
          k <= k + LW'(1);
        end
        ST_LP_END: begin
          if (found) begin
            cur.cost <= nd;
            cur.tm   <= arr[23:0];
            cur_v    <= to_idx;
            which_to <= 1'b1;
            used_r   <= 1'b1;
          end
        end
        ST_BEST2: if (vi_better) improved_r <= 1'b1;
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (clr_reply) begin
              clr_reply     <= 1'b0;
              vertex        <= 8'd0;
              reached       <= 1'b0;
              best_distance <= 24'd0;
              improved      <= 1'b0;
              edge_used     <= 1'b0;
              overflow      <= 1'b0;
            end else begin
              vertex        <= (mode_r == MODE_EDGE) ? to_r : q_r;
              reached       <= vtx_ok && vi_rdata[24];
              best_distance <= (vtx_ok && vi_rdata[24]) ? vi_rdata[23:0] : 24'd0;
              improved      <= improved_r;
              edge_used     <= used_r;
              overflow      <= ovf;
            end
          end
        end
        default: ;
      endcase
    end
  end

  `TSPE_ASSERT(a_ovf_sticky, clk, rst, (ovf && !(in_valid && in_ready && mode == MODE_CLEAR)) |=> ovf)
  `TSPE_ASSERT(a_compact_order, clk, rst, (state == ST_SC_CHK) |-> (m <= k))
  `TSPE_ASSERT(a_scan_bound, clk, rst, (state == ST_SC_RD || state == ST_LP_RD) |-> (k < n))
  `TSPE_ASSERT(a_write_in_list, clk, rst, pa_we |-> (pa_k < LIST_DEPTH))

endmodule

[test/tb_top.sv]
// self-checking testbench for temporal_shortest_path_engine_core
// depends on tspe_pkg and the engine rtl; a scoreboard class predicts every result
`timescale 1ns / 1ps

module tb_top;
  import tspe_pkg::*;

  localparam int NV = 256;
  localparam int LD = 16;
  localparam int SETTLE = 140;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [1:0]  mode;
    logic [7:0]  from_v;
    logic [7:0]  to_v;
    logic [23:0] st;
    logic [15:0] dur;
    logic [7:0]  qv;
  } request_t;

  typedef struct {
    logic [7:0]  vtx;
    logic        reached;
    logic [23:0] distance;
    logic        improved;
    logic        used;
    logic        ovf;
  } path_result_t;

  class path_scoreboard;
    int unsigned pd[NV][LD];
    int unsigned pt[NV][LD];
    int unsigned len[NV];
    int unsigned best[NV];
    bit          best_ok[NV];
    bit          halted;
    bit          ovf_seen;
    logic [7:0]  src;
    logic [23:0] win_lo;
    logic [23:0] win_hi;
    path_result_t expected_q[$];
    int          errors;

    function void init_store();
      for (int v = 0; v < NV; v++) begin
        len[v] = 0;
        best[v] = 0;
        best_ok[v] = 0;
      end
      best_ok[src] = 1;
      halted = 0;
      ovf_seen = 0;
    endfunction

    function void power_on();
      src = 0;
      win_lo = 0;
      win_hi = DIST_MAX;
      errors = 0;
      init_store();
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] val);
      case (idx)
        REG_SOURCE: src = val[7:0];
        REG_WSTART: win_lo = val;
        REG_WEND:   win_hi = val;
        default: ;
      endcase
    endfunction

    function void offer(int v, int unsigned d, int unsigned t);
      int unsigned n;
      int unsigned m;
      int unsigned pos;
      n = len[v];
      m = 0;
      for (int k = 0; k < n; k++)
        if (pd[v][k] <= d && pt[v][k] <= t) return;
      // compact out entries the new pair dominates
      for (int k = 0; k < n; k++) begin
        if (!(d <= pd[v][k] && t <= pt[v][k])) begin
          pd[v][m] = pd[v][k];
          pt[v][m] = pt[v][k];
          m++;
        end
      end
      len[v] = m;
      if (m >= LD) begin
        ovf_seen = 1;
        return;
      end
      pos = m;
      for (int k = 0; k < m; k++) begin
        if (pt[v][k] > t) begin
          pos = k;
          break;
        end
      end
      for (int k = m; k > pos; k--) begin
        pd[v][k] = pd[v][k-1];
        pt[v][k] = pt[v][k-1];
      end
      pd[v][pos] = d;
      pt[v][pos] = t;
      len[v] = m + 1;
    endfunction

    function void note_request(request_t r);
      path_result_t e;
      int unsigned arr;
      int unsigned d;
      int unsigned nd;
      bit found;
      e = '{default: 0};
      if (r.mode == MODE_CLEAR) begin
        init_store();
      end else if (r.mode == MODE_EDGE || r.mode == MODE_READ) begin
        e.vtx = (r.mode == MODE_EDGE) ? r.to_v : r.qv;
        if (r.mode == MODE_EDGE && !halted) begin
          arr = r.st + r.dur;
          if (r.st >= win_lo && arr <= win_hi) begin
            if (r.from_v == src) offer(r.from_v, 0, r.st);
            found = 0;
            d = 0;
            for (int k = 0; k < len[r.from_v]; k++) begin
              if (pt[r.from_v][k] <= r.st) begin
                d = pd[r.from_v][k];
                found = 1;
              end
            end
            if (found) begin
              nd = d + r.dur;
              if (nd > DIST_MAX) nd = DIST_MAX;
              offer(r.to_v, nd, arr);
              if (!best_ok[r.to_v] || nd < best[r.to_v]) begin
                best_ok[r.to_v] = 1;
                best[r.to_v] = nd;
                e.improved = 1;
              end
              e.used = 1;
            end
          end else if (r.st >= win_hi) begin
            halted = 1;
          end
        end
        if (best_ok[e.vtx]) begin
          e.reached = 1;
          e.distance = best[e.vtx];
        end
      end else begin
        return;
      end
      e.ovf = ovf_seen;
      expected_q = {expected_q, e};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(path_result_t g);
      path_result_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", 32'(g.vtx), 32'd0);
        return;
      end
      e = expected_q.pop_front();
      if (g.vtx !== e.vtx) report("vertex", 32'(g.vtx), 32'(e.vtx));
      if (g.reached !== e.reached) report("reached", 32'(g.reached), 32'(e.reached));
      if (g.distance !== e.distance)
        report("best_distance", 32'(g.distance), 32'(e.distance));
      if (g.improved !== e.improved) report("improved", 32'(g.improved), 32'(e.improved));
      if (g.used !== e.used) report("edge_used", 32'(g.used), 32'(e.used));
      if (g.ovf !== e.ovf) report("overflow", 32'(g.ovf), 32'(e.ovf));
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  from_vertex;
  logic [7:0]  to_vertex;
  logic [23:0] start_time;
  logic [15:0] duration;
  logic [7:0]  query_vertex;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  vertex;
  logic        reached;
  logic [23:0] best_distance;
  logic        improved;
  logic        edge_used;
  logic        overflow;

  temporal_shortest_path_engine_core u_top (.*);

  path_scoreboard sb;
  int sender_idle_pct;
  int stall_pct;
  bit hold_go;
  int hold_left;
  int quiet_cycles;

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    out_ready = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    path_result_t g;
    if (!rst && out_valid && out_ready) begin
      g.vtx = vertex;
      g.reached = reached;
      g.distance = best_distance;
      g.improved = improved;
      g.used = edge_used;
      g.ovf = overflow;
      sb.check_result(g);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[temporal_shortest_path_engine_core] ERROR");
      $finish;
    end
  end

  task send(request_t r);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    mode <= r.mode;
    from_vertex <= r.from_v;
    to_vertex <= r.to_v;
    start_time <= r.st;
    duration <= r.dur;
    query_vertex <= r.qv;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
  endtask

  task send_edge(logic [7:0] f, logic [7:0] t, logic [23:0] st, logic [15:0] dur);
    send('{MODE_EDGE, f, t, st, dur, 8'($urandom)});
  endtask

  task send_read(logic [7:0] q);
    send('{MODE_READ, 8'($urandom), 8'($urandom), 24'($urandom), 16'($urandom), q});
  endtask

  task send_clear();
    send('{MODE_CLEAR, 8'($urandom), 8'($urandom), 24'($urandom), 16'($urandom),
           8'($urandom)});
  endtask

  // sender waits for every pending result, then for any trailing work
  task drain();
    in_valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 0;
    sb.set_reg(idx, val);
  endtask

  task random_noise();
    request_t r;
    r.mode = 2'($urandom);
    r.from_v = 8'($urandom);
    r.to_v = 8'($urandom);
    r.st = 24'($urandom);
    r.dur = 16'($urandom);
    r.qv = 8'($urandom);
    send(r);
  endtask

  // time-sorted run of edges, with reads and random noise, over a small vertex group that holds the source
  task edge_run(int count, ref int sent);
    int base;
    int span;
    int unsigned t;
    int pick;
    base = sb.src;
    span = $urandom_range(3, 15);
    t = sb.win_lo + $urandom_range(0, 30);
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) begin
        random_noise();
      end else if (pick < 20) begin
        send_read(8'(base + $urandom_range(0, span)));
      end else begin
        t = t + $urandom_range(0, 40);
        if (t > DIST_MAX) t = DIST_MAX;
        send_edge(8'(base + $urandom_range(0, span)), 8'(base + $urandom_range(0, span)),
                  t[23:0], ($urandom_range(9) == 0) ? 16'($urandom) :
                  16'($urandom_range(0, 60)));
      end
      sent++;
    end
  endtask

  task random_phase(int idle_pct, int st_pct, int items, bit pressure);
    int sent;
    sent = 0;
    sender_idle_pct = idle_pct;
    stall_pct = st_pct;
    if (pressure) begin
      hold_go = 1;
      edge_run(40, sent);
    end
    while (sent < items) begin
      if ($urandom_range(3) == 0) begin
        send_clear();
        sent++;
      end
      edge_run($urandom_range(10, 60), sent);
    end
    drain();
  endtask

  initial begin
    sb = new();
    sb.power_on();
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_SOURCE;
    cfg_data = 0;
    in_valid = 0;
    mode = MODE_EDGE;
    from_vertex = 0;
    to_vertex = 0;
    start_time = 0;
    duration = 0;
    query_vertex = 0;
    hold_go = 0;
    quiet_cycles = 0;
    sender_idle_pct = 0;
    stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: source reach, zero and max durations, unreached origin
    send_read(8'd0);
    send_read(8'd255);
    send_edge(8'd0, 8'd1, 24'd0, 16'd0);
    send_edge(8'd0, 8'd2, 24'd5, 16'hFFFF);
    send_edge(8'd1, 8'd3, 24'd10, 16'd7);
    send_edge(8'd200, 8'd4, 24'd11, 16'd1);
    send('{MODE_NOP, 8'hFF, 8'hFF, 24'hFFFFFF, 16'hFFFF, 8'hFF});
    send_read(8'd3);
    // pareto list filling up on one vertex: later arrivals, shorter distances
    for (int k = 0; k < LD + 1; k++)
      send_edge(8'd0, 8'd9, 24'(100 + 10 * k), 16'(1000 - 5 * k));
    send_read(8'd9);
    // start at or past the window end halts edge processing
    send_edge(8'd0, 8'd5, 24'hFFFFFF, 16'hFFFF);
    send_edge(8'd0, 8'd6, 24'd0, 16'd1);
    send_clear();
    drain();

    // window extremes and the top source vertex
    write_reg(REG_SOURCE, 24'd255);
    write_reg(REG_WSTART, 24'hFFFFFF);
    write_reg(REG_WEND, 24'd0);
    send_clear();
    send_edge(8'd255, 8'd254, 24'hFFFFFF, 16'd0);
    send_edge(8'd255, 8'd254, 24'd0, 16'd0);
    send_read(8'd255);
    drain();
    write_reg(REG_WSTART, 24'd0);
    write_reg(REG_WEND, 24'hFFFFFF);
    send_clear();
    send_edge(8'd255, 8'd0, 24'hFF0000, 16'hFFFF);
    send_edge(8'd0, 8'd1, 24'hFFFFFF, 16'd0);

    drain();
    write_reg(REG_SOURCE, 24'd0);
    write_reg(REG_WSTART, 24'd0);
    write_reg(REG_WEND, 24'hFFFFFF);
    send_clear();
    random_phase(0, 0, 470, 1);

    write_reg(REG_SOURCE, 24'($urandom_range(0, 240)));
    write_reg(REG_WSTART, 24'd1000);
    write_reg(REG_WEND, 24'd1600);
    send_clear();
    random_phase(51, 0, 470, 0);

    write_reg(REG_SOURCE, 24'd240);
    write_reg(REG_WSTART, 24'($urandom_range(0, 24'hF00000)));
    write_reg(REG_WEND, 24'hFFFFFF);
    send_clear();
    random_phase(0, 51, 470, 0);

    write_reg(REG_SOURCE, 24'($urandom_range(0, 240)));
    write_reg(REG_WSTART, 24'd0);
    write_reg(REG_WEND, 24'($urandom_range(200, 2000)));
    random_phase(14, 14, 470, 0);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[temporal_shortest_path_engine_core] OK");
    end else begin
      $display("[temporal_shortest_path_engine_core] ERROR");
    end
    $finish;
  end

endmodule
